// File: rtl/core/lsf_pkg.sv
// Shared types, constants and saturation helper for the lattice spring force unit
package lsf_pkg;

  localparam int NEIGHBOURS = 4;
  localparam int ROOT_W     = 32;
  localparam int QUO_W      = 32;
  localparam int DIV3_CW    = 12;
  localparam int DIV3_SHIFT = 16;
  localparam logic [15:0] DIV3_RECIP = 16'd21846;

  localparam logic [1:0] REG_BOX  = 2'd0;
  localparam logic [1:0] REG_K2   = 2'd1;
  localparam logic [1:0] REG_K3   = 2'd2;
  localparam logic [1:0] REG_REST = 2'd3;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    coord_t left_x;
    coord_t left_y;
    coord_t right_x;
    coord_t right_y;
    coord_t down_x;
    coord_t down_y;
    coord_t up_x;
    coord_t up_y;
  } in_item_t;

  typedef struct packed {
    coord_t accel_x;
    coord_t accel_y;
    coord_t energy;
    logic   zero_distance;
    logic   overflow;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [30:0] box;
    coord_t      k2;
    coord_t      k3;
    logic [30:0] rest;
  } cfg_t;

  typedef struct packed {
    logic signed [32:0] fx;
    logic signed [32:0] fy;
    logic signed [32:0] e;
    logic               zero;
    logic               ovf;
  } term_t;

  typedef struct packed {
    logic   o;
    coord_t v;
  } sat_t;

  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t s;
    if (x > S32_MAX) begin
      s.o = 1'b1;
      s.v = 32'sh7FFF_FFFF;
    end else if (x < S32_MIN) begin
      s.o = 1'b1;
      s.v = 32'sh8000_0000;
    end else begin
      s.o = 1'b0;
      s.v = x[31:0];
    end
    return s;
  endfunction

endpackage

// File: rtl/core/lsf_stream_if.sv
// Valid/ready stream channel with a typed payload
interface lsf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/lsf_term.sv
// Per-neighbour pipeline: wrap, distance, stretch, force components and potential
module lsf_term
  import lsf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_valid,
  input  coord_t center_x,
  input  coord_t center_y,
  input  coord_t nb_x,
  input  coord_t nb_y,
  input  cfg_t   cfg,
  output logic   out_valid,
  output term_t  term
);

  localparam int EW  = 63 - FRAC_BITS;
  localparam int NCH = (EW + DIV3_CW - 1) / DIV3_CW;
  localparam int EP  = NCH * DIV3_CW;

  typedef struct packed {
    coord_t dx;
    coord_t dy;
    logic   ovf;
  } sb_t;

  typedef struct packed {
    logic   sx;
    logic   sy;
    logic   se;
    coord_t e2;
    logic   zero;
    logic   ovf;
    logic   oc;
  } ds_t;

  coord_t k2;
  coord_t k3;
  assign k2 = cfg.k2;
  assign k3 = cfg.k3;

  function automatic logic signed [63:0] wrap_axis(input logic signed [32:0] d,
                                                   input logic [30:0] box);
    logic signed [63:0] t;
    logic signed [63:0] b;
    t = {{31{d[32]}}, d};
    b = {33'd0, box};
    if ((t <<< 1) < -b) t = t + b;
    if ((t <<< 1) >= b) t = t - b;
    return t;
  endfunction

  // displacement
  logic               v1_r;
  logic signed [32:0] ddx_r;
  logic signed [32:0] ddy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ddx_r <= $signed({nb_x[31], nb_x}) - $signed({center_x[31], center_x});
      ddy_r <= $signed({nb_y[31], nb_y}) - $signed({center_y[31], center_y});
    end
  end

  // minimum image and clamp
  sat_t wx;
  sat_t wy;
  logic v2_r;
  sb_t  sb2_r;
  assign wx = sat32(wrap_axis(ddx_r, cfg.box));
  assign wy = sat32(wrap_axis(ddy_r, cfg.box));

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_r.dx  <= wx.v;
      sb2_r.dy  <= wy.v;
      sb2_r.ovf <= wx.o | wy.o;
    end
  end

  // squares
  logic               v3_r;
  logic signed [63:0] mxx_r;
  logic signed [63:0] myy_r;
  sb_t                sb3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mxx_r <= sb2_r.dx * sb2_r.dx;
      myy_r <= sb2_r.dy * sb2_r.dy;
      sb3_r <= sb2_r;
    end
  end

  // square root, one result bit per stage
  logic [63:0]       rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0] root_r [0:ROOT_W];
  sb_t               sqsb_r [0:ROOT_W];
  logic              sqv_r  [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) sqv_r[0] <= 1'b0;
    else if (en) sqv_r[0] <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= $unsigned(mxx_r) + $unsigned(myy_r);
      root_r[0] <= '0;
      sqsb_r[0] <= sb3_r;
    end
  end

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - g;
    logic [63:0] delta;
    assign delta = (64'(root_r[g]) << (B + 1)) | (64'd1 << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) sqv_r[g+1] <= 1'b0;
      else if (en) sqv_r[g+1] <= sqv_r[g];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[g] >= delta) begin
          rem_r[g+1]  <= rem_r[g] - delta;
          root_r[g+1] <= root_r[g] | (ROOT_W'(1) << B);
        end else begin
          rem_r[g+1]  <= rem_r[g];
          root_r[g+1] <= root_r[g];
        end
        sqsb_r[g+1] <= sqsb_r[g];
      end
    end
  end

  // stretch and polynomial terms
  logic [6:1] cv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r <= '0;
    else if (en) cv_r <= {cv_r[5:1], sqv_r[ROOT_W]};
  end

  logic [ROOT_W-1:0]  root;
  logic signed [32:0] st;
  sat_t               cs;
  assign root = root_r[ROOT_W];
  assign st   = $signed({1'b0, root}) - $signed({2'b00, cfg.rest});
  assign cs   = sat32({{31{st[32]}}, st});

  coord_t            c1_c_r;
  logic              c1_oc_r;
  logic              c1_zero_r;
  logic [ROOT_W-1:0] c1_root_r;
  sb_t               c1_sb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_c_r    <= cs.v;
      c1_oc_r   <= cs.o;
      c1_zero_r <= (root == '0);
      c1_root_r <= root;
      c1_sb_r   <= sqsb_r[ROOT_W];
    end
  end

  logic signed [63:0] c2_cc_r;
  logic signed [63:0] c2_k2c_r;
  coord_t             c2_c_r;
  logic               c2_oc_r;
  logic               c2_zero_r;
  logic [ROOT_W-1:0]  c2_root_r;
  sb_t                c2_sb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c2_cc_r   <= c1_c_r * c1_c_r;
      c2_k2c_r  <= k2 * c1_c_r;
      c2_c_r    <= c1_c_r;
      c2_oc_r   <= c1_oc_r;
      c2_zero_r <= c1_zero_r;
      c2_root_r <= c1_root_r;
      c2_sb_r   <= c1_sb_r;
    end
  end

  sat_t s2;
  assign s2 = sat32(c2_cc_r >>> FRAC_BITS);

  coord_t             c3_c2_r;
  logic signed [63:0] c3_kc_r;
  coord_t             c3_c_r;
  logic               c3_oc_r;
  logic               c3_zero_r;
  logic [ROOT_W-1:0]  c3_root_r;
  sb_t                c3_sb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c3_c2_r   <= s2.v;
      c3_kc_r   <= c2_k2c_r >>> FRAC_BITS;
      c3_c_r    <= c2_c_r;
      c3_oc_r   <= c2_oc_r | s2.o;
      c3_zero_r <= c2_zero_r;
      c3_root_r <= c2_root_r;
      c3_sb_r   <= c2_sb_r;
    end
  end

  logic signed [63:0] c4_c2c_r;
  logic signed [63:0] c4_k3c2_r;
  logic signed [63:0] c4_k2c2_r;
  logic signed [63:0] c4_kc_r;
  logic               c4_oc_r;
  logic               c4_zero_r;
  logic [ROOT_W-1:0]  c4_root_r;
  sb_t                c4_sb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c4_c2c_r  <= c3_c2_r * c3_c_r;
      c4_k3c2_r <= k3 * c3_c2_r;
      c4_k2c2_r <= k2 * c3_c2_r;
      c4_kc_r   <= c3_kc_r;
      c4_oc_r   <= c3_oc_r;
      c4_zero_r <= c3_zero_r;
      c4_root_r <= c3_root_r;
      c4_sb_r   <= c3_sb_r;
    end
  end

  sat_t s3;
  sat_t ss;
  sat_t se2;
  assign s3  = sat32(c4_c2c_r >>> FRAC_BITS);
  assign ss  = sat32(c4_kc_r + (c4_k3c2_r >>> FRAC_BITS));
  assign se2 = sat32(c4_k2c2_r >>> (FRAC_BITS + 1));

  coord_t            c5_c3_r;
  coord_t            c5_s_r;
  coord_t            c5_e2_r;
  logic              c5_oc_r;
  logic              c5_zero_r;
  logic [ROOT_W-1:0] c5_root_r;
  sb_t               c5_sb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c5_c3_r   <= s3.v;
      c5_s_r    <= ss.v;
      c5_e2_r   <= se2.v;
      c5_oc_r   <= c4_oc_r | s3.o | ss.o | se2.o;
      c5_zero_r <= c4_zero_r;
      c5_root_r <= c4_root_r;
      c5_sb_r   <= c4_sb_r;
    end
  end

  logic signed [63:0] c6_pk_r;
  logic signed [63:0] c6_px_r;
  logic signed [63:0] c6_py_r;
  coord_t             c6_e2_r;
  logic               c6_oc_r;
  logic               c6_zero_r;
  logic               c6_ovf_r;
  logic [ROOT_W-1:0]  c6_root_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c6_pk_r   <= k3 * c5_c3_r;
      c6_px_r   <= c5_s_r * c5_sb_r.dx;
      c6_py_r   <= c5_s_r * c5_sb_r.dy;
      c6_e2_r   <= c5_e2_r;
      c6_oc_r   <= c5_oc_r;
      c6_zero_r <= c5_zero_r;
      c6_ovf_r  <= c5_sb_r.ovf;
      c6_root_r <= c5_root_r;
    end
  end

  // magnitudes into the dividers
  logic [63:0] mx;
  logic [63:0] my;
  logic [63:0] mk;
  assign mx = c6_px_r[63] ? -c6_px_r : c6_px_r;
  assign my = c6_py_r[63] ? -c6_py_r : c6_py_r;
  assign mk = c6_pk_r[63] ? -c6_pk_r : c6_pk_r;

  logic [63:0]       xr_r  [0:QUO_W];
  logic [QUO_W-1:0]  xq_r  [0:QUO_W];
  logic [63:0]       yr_r  [0:QUO_W];
  logic [QUO_W-1:0]  yq_r  [0:QUO_W];
  logic [ROOT_W-1:0] dvs_r [0:QUO_W];
  logic [EP-1:0]     ew_r  [0:QUO_W];
  logic [1:0]        em_r  [0:QUO_W];
  ds_t               ds_r  [0:QUO_W];
  logic              dvv_r [0:QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) dvv_r[0] <= 1'b0;
    else if (en) dvv_r[0] <= cv_r[6];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr_r[0]       <= mx;
      xq_r[0]       <= '0;
      yr_r[0]       <= my;
      yq_r[0]       <= '0;
      dvs_r[0]      <= c6_root_r;
      ew_r[0]       <= EP'(mk >> FRAC_BITS);
      em_r[0]       <= '0;
      ds_r[0].sx    <= c6_px_r[63];
      ds_r[0].sy    <= c6_py_r[63];
      ds_r[0].se    <= c6_pk_r[63];
      ds_r[0].e2    <= c6_e2_r;
      ds_r[0].zero  <= c6_zero_r;
      ds_r[0].ovf   <= c6_ovf_r;
      ds_r[0].oc    <= c6_oc_r;
    end
  end

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    localparam int B = QUO_W - 1 - g;
    logic [63:0] dv;
    assign dv = {32'd0, dvs_r[g]} << B;

    always_ff @(posedge clk) begin
      if (!rst_n) dvv_r[g+1] <= 1'b0;
      else if (en) dvv_r[g+1] <= dvv_r[g];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (xr_r[g] >= dv) begin
          xr_r[g+1] <= xr_r[g] - dv;
          xq_r[g+1] <= xq_r[g] | (QUO_W'(1) << B);
        end else begin
          xr_r[g+1] <= xr_r[g];
          xq_r[g+1] <= xq_r[g];
        end
        if (yr_r[g] >= dv) begin
          yr_r[g+1] <= yr_r[g] - dv;
          yq_r[g+1] <= yq_r[g] | (QUO_W'(1) << B);
        end else begin
          yr_r[g+1] <= yr_r[g];
          yq_r[g+1] <= yq_r[g];
        end
        dvs_r[g+1] <= dvs_r[g];
        ds_r[g+1]  <= ds_r[g];
      end
    end

    // divide by three, one chunk per stage, quotient shifts in at the bottom
    if (g < NCH) begin : g_div3
      logic [DIV3_CW+1:0]            v3;
      logic [DIV3_CW+DIV3_SHIFT+1:0] pm;
      logic [DIV3_CW-1:0]            q3;
      logic [DIV3_CW+1:0]            q3x3;
      logic [DIV3_CW+1:0]            rm;
      assign v3   = {em_r[g], ew_r[g][EP-1 -: DIV3_CW]};
      assign pm   = v3 * DIV3_RECIP;
      assign q3   = pm[DIV3_SHIFT +: DIV3_CW];
      assign q3x3 = {1'b0, q3, 1'b0} + {2'b00, q3};
      assign rm   = v3 - q3x3;

      always_ff @(posedge clk) begin
        if (en) begin
          ew_r[g+1] <= {ew_r[g][EP-DIV3_CW-1:0], q3};
          em_r[g+1] <= rm[1:0];
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          ew_r[g+1] <= ew_r[g];
          em_r[g+1] <= em_r[g];
        end
      end
    end
  end

  // signs, cubic energy clamp, skip of a coincident neighbour
  ds_t                ds;
  logic [QUO_W-1:0]   qx;
  logic [QUO_W-1:0]   qy;
  logic [EP-1:0]      qe;
  logic signed [32:0] fxv;
  logic signed [32:0] fyv;
  logic               eo;
  coord_t             e3;
  logic signed [32:0] esum;

  assign ds  = ds_r[QUO_W];
  assign qx  = xq_r[QUO_W];
  assign qy  = yq_r[QUO_W];
  assign qe  = ew_r[QUO_W];
  assign fxv = ds.sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign fyv = ds.sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  assign eo  = ds.se ? (qe > EP'(32'h8000_0000)) : (qe > EP'(32'h7FFF_FFFF));

  always_comb begin
    if (eo) e3 = ds.se ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else e3 = ds.se ? -qe[31:0] : qe[31:0];
  end

  assign esum = $signed({ds.e2[31], ds.e2}) + $signed({e3[31], e3});

  logic  fv_r;
  term_t term_r;

  always_ff @(posedge clk) begin
    if (!rst_n) fv_r <= 1'b0;
    else if (en) fv_r <= dvv_r[QUO_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r.fx   <= ds.zero ? '0 : fxv;
      term_r.fy   <= ds.zero ? '0 : fyv;
      term_r.e    <= ds.zero ? '0 : esum;
      term_r.zero <= ds.zero;
      term_r.ovf  <= ds.ovf | (!ds.zero & (ds.oc | eo));
    end
  end

  assign out_valid = fv_r;
  assign term      = term_r;

endmodule

// File: rtl/core/lattice_spring_force_2d_unit.sv
// Top level: configuration registers, four neighbour pipelines, summation and output register
//
// Takes one atom with its four lattice neighbours per cycle and returns one transaction with the
// summed force, half the spring potential and the zero-distance and saturation flags. The pipeline
// is built around the 32-stage square root and the 32-stage divider that scales the force along
// the unit vector, with multiply stages between. A result held on the output freezes the whole
// pipeline; otherwise one item is accepted every cycle. Configuration registers feed the pipeline
// directly; the user must write them only while it is empty, which the block does not enforce.
module lattice_spring_force_2d_unit
  import lsf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  lsf_stream_if.sink   in_ch,
  lsf_stream_if.source out_ch,
  lsf_stream_if.sink   cfg_ch
);

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box  <= 31'(64'd64 << FRAC_BITS);
      cfg_r.k2   <= 32'(64'd1 << FRAC_BITS);
      cfg_r.k3   <= '0;
      cfg_r.rest <= 31'(64'd1 << FRAC_BITS);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        REG_BOX:  cfg_r.box  <= cfg_ch.data.value[30:0];
        REG_K2:   cfg_r.k2   <= cfg_ch.data.value;
        REG_K3:   cfg_r.k3   <= cfg_ch.data.value;
        REG_REST: cfg_r.rest <= cfg_ch.data.value[30:0];
      endcase
    end
  end

  logic                  en;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  coord_t                nb_x [NEIGHBOURS];
  coord_t                nb_y [NEIGHBOURS];
  logic [NEIGHBOURS-1:0] tv;
  term_t                 tr [NEIGHBOURS];

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  assign nb_x[0] = in_ch.data.left_x;
  assign nb_y[0] = in_ch.data.left_y;
  assign nb_x[1] = in_ch.data.right_x;
  assign nb_y[1] = in_ch.data.right_y;
  assign nb_x[2] = in_ch.data.down_x;
  assign nb_y[2] = in_ch.data.down_y;
  assign nb_x[3] = in_ch.data.up_x;
  assign nb_y[3] = in_ch.data.up_y;

  for (genvar j = 0; j < NEIGHBOURS; j++) begin : g_term
    lsf_term #(
      .FRAC_BITS (FRAC_BITS)
    ) u_term (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (in_ch.valid),
      .center_x  (in_ch.data.center_x),
      .center_y  (in_ch.data.center_y),
      .nb_x      (nb_x[j]),
      .nb_y      (nb_y[j]),
      .cfg       (cfg_r),
      .out_valid (tv[j]),
      .term      (tr[j])
    );
  end

  logic signed [34:0] ax;
  logic signed [34:0] ay;
  logic signed [34:0] au;
  logic signed [34:0] hu;
  logic               zs;
  logic               os;
  sat_t               sx;
  sat_t               sy;
  sat_t               su;

  always_comb begin
    ax = '0;
    ay = '0;
    au = '0;
    zs = 1'b0;
    os = 1'b0;
    for (int j = 0; j < NEIGHBOURS; j++) begin
      ax = ax + $signed({{2{tr[j].fx[32]}}, tr[j].fx});
      ay = ay + $signed({{2{tr[j].fy[32]}}, tr[j].fy});
      au = au + $signed({{2{tr[j].e[32]}}, tr[j].e});
      zs = zs | tr[j].zero;
      os = os | tr[j].ovf;
    end
  end

  assign hu = au >>> 1;
  assign sx = sat32({{29{ax[34]}}, ax});
  assign sy = sat32({{29{ay[34]}}, ay});
  assign su = sat32({{29{hu[34]}}, hu});

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= tv[0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.accel_x       <= sx.v;
      out_data_r.accel_y       <= sy.v;
      out_data_r.energy        <= su.v;
      out_data_r.zero_distance <= zs;
      out_data_r.overflow      <= os | sx.o | sy.o | su.o;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    tv == {NEIGHBOURS{tv[0]}})
    else $error("neighbour pipelines out of step");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  a_reset_clears_output: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid_r)
    else $error("output valid right after reset");

endmodule

// File: dv/lattice_spring_force_2d_unit_tb.sv
// Testbench for the lattice spring force unit: directed and random atoms checked against a predictor
`timescale 1ns / 100ps

module lattice_spring_force_2d_unit_tb;
  import lsf_pkg::*;

  localparam int  FRAC      = 16;
  localparam int  DRAIN     = 100;
  localparam int  WDOG_MAX  = 20000;
  localparam int  N_RANDOM  = 1750;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lsf_stream_if #(.payload_t(in_item_t))  in_ch ();
  lsf_stream_if #(.payload_t(out_item_t)) out_ch ();
  lsf_stream_if #(.payload_t(cfg_wr_t))   cfg_ch ();

  lattice_spring_force_2d_unit #(.FRAC_BITS(FRAC)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // register shadow
  bit [30:0]   box_q;
  int          k2_q;
  int          k3_q;
  bit [30:0]   rest_q;

  out_item_t   force_q[$];
  int          errors = 0;
  bit          calm = 1'b0;
  int          idle_cycles = 0;
  int          stall_left = 0;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint clamp32(input longint x, inout bit o);
    if (x > 64'sd2147483647) begin
      o = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      o = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint min_image(input longint d, input longint box);
    if (2 * d < -box) d += box;
    if (2 * d >= box) d -= box;
    return d;
  endfunction

  function automatic longint int_sqrt(input bit [63:0] x);
    bit [63:0] rem, res, b;
    rem = x;
    res = '0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic out_item_t spring_force(input in_item_t it);
    out_item_t o;
    bit        ovf, zero;
    longint    nx[4], ny[4];
    longint    dx, dy, r, c, c2, c3, s, e2, e3;
    longint    sx, sy, su, k2, k3;
    bit [63:0] sq;
    ovf = 0;
    zero = 0;
    sx = 0;
    sy = 0;
    su = 0;
    k2 = k2_q;
    k3 = k3_q;
    nx = '{it.left_x, it.right_x, it.down_x, it.up_x};
    ny = '{it.left_y, it.right_y, it.down_y, it.up_y};
    for (int j = 0; j < 4; j++) begin
      dx = clamp32(min_image(nx[j] - longint'(it.center_x), longint'(box_q)), ovf);
      dy = clamp32(min_image(ny[j] - longint'(it.center_y), longint'(box_q)), ovf);
      sq = 64'(dx * dx) + 64'(dy * dy);
      r = int_sqrt(sq);
      if (r == 0) begin
        zero = 1;
        continue;
      end
      c  = clamp32(r - longint'(rest_q), ovf);
      c2 = clamp32((c * c) >>> FRAC, ovf);
      c3 = clamp32((c2 * c) >>> FRAC, ovf);
      s  = clamp32(((k2 * c) >>> FRAC) + ((k3 * c2) >>> FRAC), ovf);
      sx += (s * dx) / r;
      sy += (s * dy) / r;
      e2 = clamp32((k2 * c2) >>> (FRAC + 1), ovf);
      e3 = clamp32((k3 * c3) / (longint'(3) << FRAC), ovf);
      su += e2 + e3;
    end
    o.accel_x = 32'(clamp32(sx, ovf));
    o.accel_y = 32'(clamp32(sy, ovf));
    o.energy  = 32'(clamp32(su >>> 1, ovf));
    o.zero_distance = zero;
    o.overflow = ovf;
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_atom(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    force_q.push_back(spring_force(it));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BOX:  box_q  = val[30:0];
      REG_K2:   k2_q   = val;
      REG_K3:   k3_q   = val;
      REG_REST: rest_q = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [31:0] box, k2, k3, rest);
    wait_idle();
    write_reg(REG_BOX, box);
    write_reg(REG_K2, k2);
    write_reg(REG_K3, k3);
    write_reg(REG_REST, rest);
  endtask

  // atom with neighbours near one lattice spacing away
  function automatic in_item_t lattice_atom(input int spacing, input int noise);
    in_item_t it;
    int cx, cy;
    cx = $urandom();
    cy = $urandom();
    it.center_x = cx;
    it.center_y = cy;
    it.left_x  = cx - spacing + $urandom_range(0, 2 * noise) - noise;
    it.left_y  = cy + $urandom_range(0, 2 * noise) - noise;
    it.right_x = cx + spacing + $urandom_range(0, 2 * noise) - noise;
    it.right_y = cy + $urandom_range(0, 2 * noise) - noise;
    it.down_x  = cx + $urandom_range(0, 2 * noise) - noise;
    it.down_y  = cy - spacing + $urandom_range(0, 2 * noise) - noise;
    it.up_x    = cx + $urandom_range(0, 2 * noise) - noise;
    it.up_y    = cy + spacing + $urandom_range(0, 2 * noise) - noise;
    return it;
  endfunction

  function automatic in_item_t noise_atom();
    in_item_t it;
    for (int i = 0; i < 10; i++) it[i*32 +: 32] = $urandom();
    return it;
  endfunction

  task automatic test_reset_values();
    calm = 1'b1;
    send_atom(lattice_atom(32'h0001_0000, 32'h4000));
    send_atom(lattice_atom(32'h0001_8000, 0));
    send_atom(lattice_atom(32'h0000_8000, 32'h100));
    calm = 1'b0;
  endtask

  task automatic test_field_extremes();
    in_item_t it;
    it = '{default: 32'sh7FFF_FFFF};
    it.center_x = 32'sh8000_0000;
    send_atom(it);
    it = '{default: 32'sh8000_0000};
    it.center_y = 32'sh7FFF_FFFF;
    send_atom(it);
    it = '{default: 32'sh0000_0000};
    it.left_x = 32'sh7FFF_FFFF;
    it.right_y = 32'sh8000_0000;
    it.up_x = 32'sh0000_0001;
    it.down_y = -32'sd1;
    send_atom(it);
  endtask

  task automatic test_coincident();
    in_item_t it;
    it = lattice_atom(32'h0001_0000, 0);
    it.up_x = it.center_x;
    it.up_y = it.center_y;
    send_atom(it);
    it = '{default: 32'sh1234_5678};
    send_atom(it);
  endtask

  task automatic test_zero_box();
    set_all(32'd0, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000);
    send_atom(lattice_atom(32'h0001_0000, 32'h2000));
    send_atom(noise_atom());
    set_all(32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    send_atom(lattice_atom(32'h0001_0000, 32'h2000));
    send_atom(noise_atom());
  endtask

  task automatic test_saturation();
    set_all(32'h0040_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
    send_atom(lattice_atom(32'h0010_0000, 32'h1000));
    send_atom(noise_atom());
    set_all(32'h0040_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
    send_atom(lattice_atom(32'h0020_0000, 0));
    send_atom(noise_atom());
    set_all(32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0003_0000, 32'h0001_0000);
    send_atom(noise_atom());
  endtask

  task automatic test_random_sweep();
    logic [31:0] box, k2, k3, rest;
    int p;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: box = $urandom_range(32'h0008_0000, 32'h0100_0000);
        1: box = 32'd0;
        2: box = 32'h7FFF_FFFF;
        default: box = $urandom();
      endcase
      k2 = (ph % 3 == 0) ? $urandom() : $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      k3 = (ph % 4 == 0) ? $urandom() : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      rest = (ph == 7) ? 32'h7FFF_FFFF : (ph == 8) ? 32'd0 :
             $urandom_range(32'h0000_4000, 32'h0004_0000);
      set_all(box, k2, k3, rest);
      calm = (ph == 3);
      for (int i = 0; i < N_RANDOM / 10; i++) begin
        p = $urandom_range(0, 99);
        if (p < 70) send_atom(lattice_atom(rest, $urandom_range(0, 32'h8000)));
        else if (p < 80) send_atom(lattice_atom($urandom_range(0, 32'h0080_0000), 32'h100));
        else if (p < 85) send_atom(lattice_atom(rest, 0));
        else send_atom(noise_atom());
      end
      calm = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
    end
  end

  task automatic check_field(input string name, input longint exp, input longint act);
    if (exp != act) begin
      errors++;
      $display("%0t %s expected %0d actual %0d", $time, name, exp, act);
    end
  endtask

  always @(posedge clk) begin
    out_item_t e, a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (force_q.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction accel_x %0d", $time, a.accel_x);
      end else begin
        e = force_q.pop_front();
        check_field("accel_x", e.accel_x, a.accel_x);
        check_field("accel_y", e.accel_y, a.accel_y);
        check_field("energy", e.energy, a.energy);
        check_field("zero_distance", e.zero_distance, a.zero_distance);
        check_field("overflow", e.overflow, a.overflow);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("lattice_spring_force_2d_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    box_q  = 31'h0040_0000;
    k2_q   = 32'h0001_0000;
    k3_q   = 0;
    rest_q = 31'h0001_0000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_field_extremes();
    test_coincident();
    test_zero_box();
    test_saturation();
    test_random_sweep();
    wait_idle();
    if (errors == 0) begin
      $display("lattice_spring_force_2d_unit: match");
    end else begin
      $display("lattice_spring_force_2d_unit: mismatch");
    end
    $finish;
  end

endmodule
